// File: sv/sld_pkg.sv
// shared types and constants for the skip list dictionary
// no dependencies
package sld_pkg;

    localparam logic [31:0] RESERVED_KEY = 32'h7fffffff;
    localparam logic [31:0] LFSR_TAPS    = 32'h80200003;
    localparam logic [5:0]  TRIAL_LAST   = 6'd63;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_POOL_FULL = 2'd2;
    localparam logic [1:0] STATUS_RESERVED  = 2'd3;

    typedef struct packed {
        logic rd;
        logic pop;
        logic push;
    } free_op_t;

    function automatic logic [31:0] lfsr_step(input logic [31:0] s);
        logic [31:0] r;
        r = s >> 1;
        if (s[0])
        begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage

// File: sv/sld_node_mem.sv
// key and value store, one entry per node, registered read
// no dependencies
module sld_node_mem #(
    parameter int NODE_COUNT = 1024
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(NODE_COUNT)-1:0] waddr,
    input  logic [31:0]                   wkey,
    input  logic [31:0]                   wval,
    input  logic                          re,
    input  logic [$clog2(NODE_COUNT)-1:0] raddr,
    output logic [31:0]                   rkey,
    output logic [31:0]                   rval
);
    logic [31:0] key_mem [NODE_COUNT];
    logic [31:0] val_mem [NODE_COUNT];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr] <= wkey;
            val_mem[waddr] <= wval;
        end
        if (re)
        begin
            rkey <= key_mem[raddr];
            rval <= val_mem[raddr];
        end
    end
endmodule

// File: sv/sld_link_mem.sv
// forward link store, one row per node plus the header row
// header row reads as null until written; no package dependency
module sld_link_mem #(
    parameter int NODE_COUNT  = 1024,
    parameter int LEVEL_COUNT = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              we,
    input  logic [$clog2(NODE_COUNT+1)-1:0]   wrow,
    input  logic [$clog2(LEVEL_COUNT)-1:0]    wlvl,
    input  logic [$clog2(NODE_COUNT+2)-1:0]   wdata,
    input  logic [$clog2(NODE_COUNT+1)-1:0]   rrow,
    input  logic [$clog2(LEVEL_COUNT)-1:0]    rlvl,
    output logic [$clog2(NODE_COUNT+2)-1:0]   rdata
);
    localparam int ROW_W  = $clog2(NODE_COUNT + 1);
    localparam int LVL_W  = $clog2(LEVEL_COUNT);
    localparam int LINK_W = $clog2(NODE_COUNT + 2);
    localparam int DEPTH  = (NODE_COUNT + 1) * (1 << LVL_W);
    localparam logic [ROW_W-1:0]  HEAD_ROW  = ROW_W'(NODE_COUNT);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODE_COUNT + 1);

    logic [LINK_W-1:0]      link_mem [DEPTH];
    logic [LINK_W-1:0]      rd_reg;
    logic                   head_null_reg;
    logic [LEVEL_COUNT-1:0] hdr_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            link_mem[{wrow, wlvl}] <= wdata;
        end
        rd_reg        <= link_mem[{rrow, rlvl}];
        head_null_reg <= (rrow == HEAD_ROW) && !hdr_valid_reg[rlvl];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_valid_reg <= '0;
        end
        else if (we && (wrow == HEAD_ROW))
        begin
            hdr_valid_reg[wlvl] <= 1'b1;
        end
    end

    assign rdata = head_null_reg ? NULL_LINK : rd_reg;
endmodule

// File: sv/sld_free_pool.sv
// stack of free node indices with fill count and low-water mark
// uses sld_pkg for the operation struct
module sld_free_pool #(
    parameter int NODE_COUNT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sld_pkg::free_op_t             op,
    input  logic [$clog2(NODE_COUNT)-1:0] push_idx,
    output logic [$clog2(NODE_COUNT)-1:0] rd_idx,
    output logic                          empty
);
    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int CNT_W = $clog2(NODE_COUNT + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NODE_COUNT);

    logic [IDX_W-1:0] free_mem [NODE_COUNT];
    logic [IDX_W-1:0] mem_rd_reg;
    logic [IDX_W-1:0] idx_rd_reg;
    logic             use_mem_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] min_reg;
    logic [CNT_W-1:0] min_next;
    logic [CNT_W-1:0] top_pos;

    assign top_pos = count_reg - CNT_W'(1);
    assign empty   = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (op.push && (count_reg < FULL_CNT))
        begin
            free_mem[count_reg[IDX_W-1:0]] <= push_idx;
        end
        if (op.rd)
        begin
            mem_rd_reg  <= free_mem[top_pos[IDX_W-1:0]];
            idx_rd_reg  <= top_pos[IDX_W-1:0];
            use_mem_reg <= (top_pos >= min_reg);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        min_next   = min_reg;
        if (op.pop && !empty)
        begin
            count_next = top_pos;
            if (top_pos < min_reg)
            begin
                min_next = top_pos;
            end
        end
        else if (op.push && (count_reg < FULL_CNT))
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= FULL_CNT;
            min_reg   <= FULL_CNT;
        end
        else
        begin
            count_reg <= count_next;
            min_reg   <= min_next;
        end
    end

    assign rd_idx = use_mem_reg ? mem_rd_reg : idx_rd_reg;
endmodule

// File: sv/skip_list_dictionary_core.sv
// skip list dictionary top level: command sequencer, level lfsr, result register
// depends on sld_pkg, sld_node_mem, sld_link_mem, sld_free_pool

// One command is taken at a time and answered with one status word. Every step of the
// walk goes through the single read port of the link memory: each link read is followed,
// where the link points at a node, by a fetch of that node's key. An insert then adds the
// level draw, the free-pool pop and a link write pair per linked level; a delete unlinks
// the node level by level and trims empty header levels. Reserved keys, a full pool and
// the unused command are answered without a walk. The header row reads as null from
// reset through per-level flags, so no clearing pass is needed. A finished word waits in
// the output register while the next command is accepted.
module skip_list_dictionary_core #(
    parameter int NODE_COUNT  = 1024,
    parameter int LEVEL_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [31:0] key,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] found_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int ROW_W  = $clog2(NODE_COUNT + 1);
    localparam int LINK_W = $clog2(NODE_COUNT + 2);
    localparam int LVL_W  = $clog2(LEVEL_COUNT);
    localparam logic [ROW_W-1:0]  HEAD_ROW  = ROW_W'(NODE_COUNT);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODE_COUNT + 1);
    localparam logic [LINK_W-1:0] NODE_LIM  = LINK_W'(NODE_COUNT);
    localparam logic [LVL_W-1:0]  MAX_LVL   = LVL_W'(LEVEL_COUNT - 1);

    typedef enum logic [16:0] {
        ST_IDLE  = 17'h00001,
        ST_WRD   = 17'h00002,
        ST_WLNK  = 17'h00004,
        ST_WKEY  = 17'h00008,
        ST_FIN   = 17'h00010,
        ST_DRAW  = 17'h00020,
        ST_POP   = 17'h00040,
        ST_IRD   = 17'h00080,
        ST_IWN   = 17'h00100,
        ST_IWP   = 17'h00200,
        ST_DRD   = 17'h00400,
        ST_DCMP  = 17'h00800,
        ST_DWR   = 17'h01000,
        ST_DFREE = 17'h02000,
        ST_LRD   = 17'h04000,
        ST_LCHK  = 17'h08000,
        ST_DONE  = 17'h10000
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [31:0]       key_reg, key_next;
    logic [31:0]       val_reg, val_next;
    logic [ROW_W-1:0]  p_reg, p_next;
    logic [LINK_W-1:0] q_reg, q_next;
    logic [LVL_W-1:0]  k_reg, k_next;
    logic [LVL_W-1:0]  top_reg, top_next;
    logic [IDX_W-1:0]  n_reg, n_next;
    logic [31:0]       lfsr_reg, lfsr_next;
    logic [LVL_W-1:0]  draw_reg, draw_next;
    logic [5:0]        trial_reg, trial_next;
    logic [ROW_W-1:0]  pred_reg [LEVEL_COUNT];
    logic [ROW_W-1:0]  pred_next [LEVEL_COUNT];
    logic [1:0]        res_status_reg, res_status_next;
    logic [31:0]       res_found_reg, res_found_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [31:0]       found_reg, found_next;

    logic              link_we;
    logic [ROW_W-1:0]  link_wrow;
    logic [LVL_W-1:0]  link_wlvl;
    logic [LINK_W-1:0] link_wdata;
    logic [ROW_W-1:0]  link_rrow;
    logic [LVL_W-1:0]  link_rlvl;
    logic [LINK_W-1:0] link_rdata;
    logic              node_we;
    logic              node_re;
    logic [IDX_W-1:0]  node_raddr;
    logic [31:0]       node_rkey;
    logic [31:0]       node_rval;
    sld_pkg::free_op_t free_op;
    logic [IDX_W-1:0]  free_push_idx;
    logic [IDX_W-1:0]  free_rd_idx;
    logic              free_empty;

    logic [31:0]       lfsr_two;
    logic [LVL_W-1:0]  lvl_inc;
    logic              draw_end;
    logic              found;

    sld_node_mem #(.NODE_COUNT(NODE_COUNT)) u_node (
        .clk   (clk),
        .we    (node_we),
        .waddr (n_next),
        .wkey  (key_reg),
        .wval  (val_reg),
        .re    (node_re),
        .raddr (node_raddr),
        .rkey  (node_rkey),
        .rval  (node_rval)
    );

    sld_link_mem #(.NODE_COUNT(NODE_COUNT), .LEVEL_COUNT(LEVEL_COUNT)) u_link (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (link_we),
        .wrow  (link_wrow),
        .wlvl  (link_wlvl),
        .wdata (link_wdata),
        .rrow  (link_rrow),
        .rlvl  (link_rlvl),
        .rdata (link_rdata)
    );

    sld_free_pool #(.NODE_COUNT(NODE_COUNT)) u_free (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (free_op),
        .push_idx (free_push_idx),
        .rd_idx   (free_rd_idx),
        .empty    (free_empty)
    );

    assign lfsr_two = sld_pkg::lfsr_step(sld_pkg::lfsr_step(lfsr_reg));
    assign draw_end = (lfsr_two[1:0] != 2'b00) || (trial_reg == sld_pkg::TRIAL_LAST);
    assign found    = (q_reg < NODE_LIM) && (node_rkey == key_reg);

    always_comb
    begin
        if (lfsr_two[1:0] != 2'b00 || draw_reg == MAX_LVL)
        begin
            lvl_inc = draw_reg;
        end
        else
        begin
            lvl_inc = draw_reg + LVL_W'(1);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        k_next          = k_reg;
        top_next        = top_reg;
        n_next          = n_reg;
        lfsr_next       = lfsr_reg;
        draw_next       = draw_reg;
        trial_next      = trial_reg;
        pred_next       = pred_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        found_next      = found_reg;
        link_we         = 1'b0;
        link_wrow       = pred_reg[k_reg];
        link_wlvl       = k_reg;
        link_wdata      = link_rdata;
        link_rrow       = pred_reg[k_reg];
        link_rlvl       = k_reg;
        node_we         = 1'b0;
        node_re         = 1'b0;
        node_raddr      = link_rdata[IDX_W-1:0];
        free_op         = '0;
        free_push_idx   = q_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next       = command;
                    key_next       = key;
                    val_next       = value;
                    res_found_next = '0;
                    p_next         = HEAD_ROW;
                    k_next         = top_reg;
                    if (key == sld_pkg::RESERVED_KEY)
                    begin
                        res_status_next = sld_pkg::STATUS_RESERVED;
                        state_next      = ST_DONE;
                    end
                    else if (command == sld_pkg::CMD_INSERT && free_empty)
                    begin
                        res_status_next = sld_pkg::STATUS_POOL_FULL;
                        state_next      = ST_DONE;
                    end
                    else if (command == sld_pkg::CMD_UNUSED)
                    begin
                        res_status_next = sld_pkg::STATUS_NOT_FOUND;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_WRD;
                    end
                end
            end
            ST_WRD:
            begin
                link_rrow  = p_reg;
                state_next = ST_WLNK;
            end
            ST_WLNK:
            begin
                q_next = link_rdata;
                if (link_rdata >= NODE_LIM)
                begin
                    pred_next[k_reg] = p_reg;
                    if (k_reg == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        k_next     = k_reg - LVL_W'(1);
                        state_next = ST_WRD;
                    end
                end
                else
                begin
                    node_re    = 1'b1;
                    state_next = ST_WKEY;
                end
            end
            ST_WKEY:
            begin
                if ($signed(node_rkey) >= $signed(key_reg))
                begin
                    pred_next[k_reg] = p_reg;
                    if (k_reg == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        k_next     = k_reg - LVL_W'(1);
                        state_next = ST_WRD;
                    end
                end
                else
                begin
                    p_next     = q_reg[ROW_W-1:0];
                    state_next = ST_WRD;
                end
            end
            ST_FIN:
            begin
                k_next = '0;
                priority if (cmd_reg == sld_pkg::CMD_INSERT)
                begin
                    draw_next  = '0;
                    trial_next = '0;
                    state_next = ST_DRAW;
                end
                else if (found && cmd_reg == sld_pkg::CMD_DELETE)
                begin
                    state_next = ST_DRD;
                end
                else if (found)
                begin
                    res_status_next = sld_pkg::STATUS_OK;
                    res_found_next  = node_rval;
                    state_next      = ST_DONE;
                end
                else
                begin
                    res_status_next = sld_pkg::STATUS_NOT_FOUND;
                    state_next      = ST_DONE;
                end
            end
            ST_DRAW:
            begin
                lfsr_next = lfsr_two;
                if (!draw_end)
                begin
                    draw_next  = lvl_inc;
                    trial_next = trial_reg + 6'd1;
                end
                else
                begin
                    free_op.rd = 1'b1;
                    state_next = ST_POP;
                    if (lvl_inc > top_reg)
                    begin
                        top_next            = top_reg + LVL_W'(1);
                        k_next              = top_reg + LVL_W'(1);
                        pred_next[top_next] = HEAD_ROW;
                    end
                    else
                    begin
                        k_next = lvl_inc;
                    end
                end
            end
            ST_POP:
            begin
                n_next      = free_rd_idx;
                free_op.pop = 1'b1;
                node_we     = 1'b1;
                state_next  = ST_IRD;
            end
            ST_IRD:
            begin
                state_next = ST_IWN;
            end
            ST_IWN:
            begin
                link_we    = 1'b1;
                link_wrow  = ROW_W'(n_reg);
                state_next = ST_IWP;
            end
            ST_IWP:
            begin
                link_we    = 1'b1;
                link_wdata = LINK_W'(n_reg);
                if (k_reg == '0)
                begin
                    res_status_next = sld_pkg::STATUS_OK;
                    state_next      = ST_DONE;
                end
                else
                begin
                    k_next     = k_reg - LVL_W'(1);
                    state_next = ST_IRD;
                end
            end
            ST_DRD:
            begin
                state_next = ST_DCMP;
            end
            ST_DCMP:
            begin
                if (link_rdata == q_reg)
                begin
                    link_rrow  = q_reg[ROW_W-1:0];
                    state_next = ST_DWR;
                end
                else
                begin
                    state_next = ST_DFREE;
                end
            end
            ST_DWR:
            begin
                link_we = 1'b1;
                if (k_reg == top_reg)
                begin
                    state_next = ST_DFREE;
                end
                else
                begin
                    k_next     = k_reg + LVL_W'(1);
                    state_next = ST_DRD;
                end
            end
            ST_DFREE:
            begin
                free_op.push = 1'b1;
                state_next   = ST_LRD;
            end
            ST_LRD:
            begin
                link_rrow = HEAD_ROW;
                link_rlvl = top_reg;
                if (top_reg == '0)
                begin
                    res_status_next = sld_pkg::STATUS_OK;
                    state_next      = ST_DONE;
                end
                else
                begin
                    state_next = ST_LCHK;
                end
            end
            ST_LCHK:
            begin
                if (link_rdata == NULL_LINK)
                begin
                    top_next   = top_reg - LVL_W'(1);
                    state_next = ST_LRD;
                end
                else
                begin
                    res_status_next = sld_pkg::STATUS_OK;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    found_next     = res_found_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            lfsr_next = (cfg_data == '0) ? 32'd1 : cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            lfsr_reg      <= 32'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        k_reg          <= k_next;
        n_reg          <= n_next;
        draw_reg       <= draw_next;
        trial_reg      <= trial_next;
        pred_reg       <= pred_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_value = found_reg;
endmodule

// File: sv/sld_checker.sv
// port-level checks for the skip list dictionary, bound to the top level
// depends on sld_pkg and skip_list_dictionary_core
module sld_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [31:0] found_value
);
    // held result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(found_value))
        else $error("result word changed while stalled");

    // one command in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second command taken while busy");

    // quiet in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid && !in_stall)
        else $error("activity during reset");

    // value only on success
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != sld_pkg::STATUS_OK) |-> found_value == '0)
        else $error("nonzero value with failing status");
endmodule

bind skip_list_dictionary_core sld_checker u_sld_checker (.*);
